>>> hw/rtl/wpf_pkg.sv
// Shared types, codes and constants of the waypoint heading follower.
// Depends on nothing; the top level, the CORDIC unit and the testbench import it.
package wpf_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int ROUTE_DEPTH_DEF  = 64;
    localparam int CORDIC_STEPS_DEF = 16;

    // Width of the reported waypoint index, fixed by the result format.
    localparam int OUT_IDX_W = 7;

    // Register reset values.
    localparam logic [14:0] TURN_THR_RST     = 15'd3277;
    localparam logic [14:0] STRAIGHT_THR_RST = 15'd910;
    localparam logic [11:0] ARRIVE_RAD_RST   = 12'd50;

    typedef enum logic [1:0] {
        REG_TURN_THR     = 2'd0,
        REG_STRAIGHT_THR = 2'd1,
        REG_ARRIVE_RAD   = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_POSE   = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_FORWARD     = 3'd1,
        CMD_LEFT        = 3'd2,
        CMD_RIGHT       = 3'd3,
        CMD_FRONT_LEFT  = 3'd4,
        CMD_FRONT_RIGHT = 3'd5,
        CMD_STOP        = 3'd6
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIFF,
        S_START,
        S_SQX,
        S_SQY,
        S_SQR,
        S_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]   kind;
        logic [15:0]  coord_x;
        logic [15:0]  coord_y;
        logic [15:0]  heading;
    } item_t;

    typedef struct packed {
        cmd_t                  command;
        logic                  arrived;
        logic                  route_done;
        logic [OUT_IDX_W-1:0]  waypoint_index;
        logic                  store_full;
    } result_t;

    // Arctangent of 2^-i as a 32-bit binary angle (2^31 equals pi).
    function automatic logic [31:0] wpf_atan(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051D;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/waypoint_heading_follower_top.sv
// Waypoint heading follower. Items arrive as beats on the item channel and each
// one yields exactly one beat on the result channel. An append or a clear, or a
// pose with no waypoint left, goes from S_EXEC straight to S_DONE, which loads
// its result into the output register. A pose with a waypoint to follow goes
// through S_DIFF, S_START, S_SQX, S_SQY, S_SQR and S_WAIT to S_DONE. A pose
// exactly on its waypoint skips the CORDIC steps. The iterative CORDIC unit
// resolves one bit of bearing per cycle while one shared 17x17 multiplier
// forms dx^2, dy^2 and the squared arrival radius.
// item_stall is high from acceptance until the result is placed in the output
// register; that register lets the next item be taken while a result waits.
// A result still held by a stalled receiver delays the next one.
// Configuration goes through the APB port; the user writes it only while idle.
// The block does not enforce this. Depends on wpf_pkg, wpf_ram and wpf_cordic.
module waypoint_heading_follower_top
    import wpf_pkg::*;
#(
    parameter int ROUTE_DEPTH  = ROUTE_DEPTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  item_t        item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_t      result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W  = $clog2(ROUTE_DEPTH + 1);
    localparam int ADDR_W = $clog2(ROUTE_DEPTH);

    state_t              state_reg, state_next;
    item_t               item_reg;
    logic [IDX_W-1:0]    count_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [14:0]         turn_thr_reg;
    logic [14:0]         straight_thr_reg;
    logic [11:0]         arrive_rad_reg;
    logic signed [16:0]  dx_reg, dy_reg;
    logic signed [33:0]  prod_reg;
    logic [33:0]         d2_reg;
    cmd_t                cmd_reg, cmd_next;
    logic                arrived_reg;
    logic                full_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    logic                ram_we, ram_re;
    logic [31:0]         ram_rdata;
    logic                cordic_start, cordic_done;
    logic [15:0]         bearing;
    logic signed [16:0]  mul_a;
    logic                store_room;
    logic                has_target;
    logic                slot_free;
    logic                cfg_write;
    logic                arrive_now;

    assign store_room = count_reg < IDX_W'(ROUTE_DEPTH);
    assign has_target = idx_reg < count_reg;
    assign slot_free  = !result_valid_reg || !result_stall;
    assign cfg_write  = psel && penable && pwrite;

    wpf_ram #(
        .WIDTH (32),
        .DEPTH (ROUTE_DEPTH)
    ) u_route (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({item_reg.coord_y, item_reg.coord_x}),
        .re    (ram_re),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    wpf_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .done    (cordic_done),
        .bearing (bearing)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (item_reg.kind == KIND_POSE && has_target)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIFF:  state_next = S_START;
            S_START: state_next = S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_SQR;
            S_SQR:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (cordic_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        item_stall   = 1'b1;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        cordic_start = 1'b0;
        mul_a        = dx_reg;
        case (state_reg)
            S_IDLE:  item_stall = 1'b0;
            S_EXEC:
            begin
                ram_we = (item_reg.kind == KIND_APPEND) && store_room;
                ram_re = 1'b1;
            end
            S_START: cordic_start = 1'b1;
            S_SQX:   mul_a = dx_reg;
            S_SQY:   mul_a = dy_reg;
            // The squared radius is held while the CORDIC unit finishes.
            S_SQR, S_WAIT: mul_a = $signed({5'b0, arrive_rad_reg});
            default: mul_a = dx_reg;
        endcase
    end

    // Steering decision from the heading error, and the arrival test.
    always_comb
    begin
        logic [15:0]         err;
        logic signed [16:0]  err_ext;
        logic [16:0]         mag;
        err = item_reg.heading - bearing;
        err_ext = $signed({err[15], err});
        mag = err[15] ? 17'(-err_ext) : 17'(err_ext);
        if (mag > {2'b0, turn_thr_reg})
        begin
            cmd_next = err[15] ? CMD_LEFT : CMD_RIGHT;
        end
        else if (mag < {2'b0, straight_thr_reg})
        begin
            cmd_next = CMD_FORWARD;
        end
        else
        begin
            cmd_next = err[15] ? CMD_FRONT_LEFT : CMD_FRONT_RIGHT;
        end
        arrive_now = d2_reg < 34'(prod_reg);
        if (arrive_now)
        begin
            cmd_next = CMD_STOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
            turn_thr_reg     <= TURN_THR_RST;
            straight_thr_reg <= STRAIGHT_THR_RST;
            arrive_rad_reg   <= ARRIVE_RAD_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_TURN_THR:     turn_thr_reg     <= pwdata[14:0];
                    REG_STRAIGHT_THR: straight_thr_reg <= pwdata[14:0];
                    REG_ARRIVE_RAD:   arrive_rad_reg   <= pwdata[11:0];
                    default:          ;
                endcase
            end
            if (state_reg == S_EXEC)
            begin
                case (item_reg.kind)
                    KIND_APPEND:
                    begin
                        if (store_room)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        count_reg <= '0;
                        idx_reg   <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_WAIT && cordic_done && arrive_now)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == S_DONE && slot_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
        begin
            item_reg <= item;
        end
        if (state_reg == S_DIFF)
        begin
            dx_reg <= $signed({ram_rdata[15], ram_rdata[15:0]})
                    - $signed({item_reg.coord_x[15], item_reg.coord_x});
            dy_reg <= $signed({ram_rdata[31], ram_rdata[31:16]})
                    - $signed({item_reg.coord_y[15], item_reg.coord_y});
        end
        prod_reg <= mul_a * mul_a;
        // dx^2 lands in d2 during the dy^2 product, dy^2 is added during r^2.
        if (state_reg == S_SQY)
        begin
            d2_reg <= 34'(prod_reg);
        end
        else if (state_reg == S_SQR)
        begin
            d2_reg <= d2_reg + 34'(prod_reg);
        end
        if (state_reg == S_EXEC)
        begin
            cmd_reg     <= CMD_NONE;
            arrived_reg <= 1'b0;
            full_reg    <= (item_reg.kind == KIND_APPEND) && !store_room;
        end
        else if (state_reg == S_WAIT && cordic_done)
        begin
            cmd_reg     <= cmd_next;
            arrived_reg <= arrive_now;
        end
        if (state_reg == S_DONE && slot_free)
        begin
            result_reg.command        <= cmd_reg;
            result_reg.arrived        <= arrived_reg;
            result_reg.route_done     <= !has_target;
            result_reg.waypoint_index <= OUT_IDX_W'(idx_reg);
            result_reg.store_full     <= full_reg;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TURN_THR:     prdata = {17'b0, turn_thr_reg};
            REG_STRAIGHT_THR: prdata = {17'b0, straight_thr_reg};
            REG_ARRIVE_RAD:   prdata = {20'b0, arrive_rad_reg};
            default:          prdata = 32'b0;
        endcase
    end

    assign pready       = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> hw/rtl/wpf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the route of waypoints.
module wpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/wpf_cordic.sv
// Iterative CORDIC vectoring unit: bearing of (dx, dy) as a 16-bit binary angle.
// Depends on wpf_pkg for the arctangent table.
module wpf_cordic
    import wpf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [16:0]  dx,
    input  logic signed [16:0]  dy,
    output logic                done,
    output logic [15:0]         bearing
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic signed [39:0]  x_reg, x_next;
    logic signed [39:0]  y_reg, y_next;
    logic [31:0]         acc_reg, acc_next;
    logic [STEP_W-1:0]   step_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [31:0]         acc_round;

    always_comb
    begin
        logic signed [39:0] xs;
        logic signed [39:0] ys;
        logic signed [39:0] x0;
        logic signed [39:0] y0;
        logic [31:0]        ang;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        ang = wpf_atan(5'(step_reg));
        x0 = {{3{dx[16]}}, dx, 20'b0};
        y0 = {{3{dy[16]}}, dy, 20'b0};
        x_next = x_reg;
        y_next = y_reg;
        acc_next = acc_reg;
        if (start)
        begin
            // Fold the left half plane onto the right one before the steps.
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_next = y0;
                    y_next = -x0;
                    acc_next = 32'h40000000;
                end
                else
                begin
                    x_next = -y0;
                    y_next = x0;
                    acc_next = 32'hC0000000;
                end
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                acc_next = 32'h0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                acc_next = acc_reg + ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                acc_next = acc_reg - ang;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= '0;
            // A point on the waypoint itself has bearing zero and needs no steps.
            if (dx == 17'sd0 && dy == 17'sd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && dx == 17'sd0 && dy == 17'sd0)
        begin
            acc_reg <= 32'h0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign acc_round = acc_reg + 32'h00008000;
    assign bearing   = acc_round[31:16];
    assign done      = done_reg;

endmodule

>>> tb/waypoint_heading_follower_top_tb.sv
// Self-checking testbench for waypoint_heading_follower_top: routes, poses and clears in,
// steering results out, with a bit-exact CORDIC bearing predictor in the bench.
// Depends on wpf_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module waypoint_heading_follower_top_tb;
    import wpf_pkg::*;

    localparam int ROUTE_DEPTH     = ROUTE_DEPTH_DEF;
    localparam int CORDIC_STEPS    = CORDIC_STEPS_DEF;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 30;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int PHASES          = 5;

    // Arctangent of 2^-i as a 32-bit binary angle, entry 0 in the top word.
    localparam logic [16*32-1:0] ATAN_STEPS = {
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    item_t       pending_items[$];
    result_t     expected_results[$];
    int          queued = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          pressure_done = 1'b0;
    bit          no_gaps = 1'b0;

    // Bench copy of the route and of the thresholds.
    logic [15:0] route_x [ROUTE_DEPTH];
    logic [15:0] route_y [ROUTE_DEPTH];
    int          route_len = 0;
    int          route_pos = 0;
    int          turn_thr = 3277;
    int          straight_thr = 910;
    int          arrive_rad = 50;

    waypoint_heading_follower_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bearing of (dx, dy) as a 16-bit binary angle: quadrant fold, then vectoring steps.
    function automatic logic [15:0] bearing_of(input int dx, input int dy);
        longint      vx;
        longint      vy;
        longint      sx;
        longint      sy;
        longint      tmp;
        logic [31:0] ang;
        ang = '0;
        if (dx == 0 && dy == 0)
            return 16'd0;
        vx = longint'(dx) * 1048576;
        vy = longint'(dy) * 1048576;
        if (vx < 0)
        begin
            if (vy >= 0)
            begin
                tmp = vx; vx = vy; vy = -tmp; ang = 32'h4000_0000;
            end
            else
            begin
                tmp = vx; vx = -vy; vy = tmp; ang = 32'hC000_0000;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0)
            begin
                vx = vx + sy; vy = vy - sx; ang = ang + ATAN_STEPS[(15 - i) * 32 +: 32];
            end
            else
            begin
                vx = vx - sy; vy = vy + sx; ang = ang - ATAN_STEPS[(15 - i) * 32 +: 32];
            end
        end
        ang = ang + 32'h8000;
        return ang[31:16];
    endfunction

    // Advances the bench route state by one item and returns the steering result it yields.
    function automatic result_t steer_predict(input item_t it);
        result_t            r;
        int                 gx;
        int                 gy;
        int                 dx;
        int                 dy;
        int                 mag;
        logic signed [15:0] err;
        longint             d2;
        longint             r2;
        r = '0;
        r.command = CMD_NONE;
        case (it.kind)
            KIND_APPEND:
            begin
                if (route_len < ROUTE_DEPTH)
                begin
                    route_x[route_len] = it.coord_x;
                    route_y[route_len] = it.coord_y;
                    route_len++;
                end
                else
                    r.store_full = 1'b1;
            end
            KIND_CLEAR:
            begin
                route_len = 0;
                route_pos = 0;
            end
            KIND_POSE:
            begin
                if (route_pos < route_len)
                begin
                    gx = $signed(route_x[route_pos]);
                    gy = $signed(route_y[route_pos]);
                    dx = gx - $signed(it.coord_x);
                    dy = gy - $signed(it.coord_y);
                    err = $signed(it.heading) - $signed(bearing_of(dx, dy));
                    mag = (err < 0) ? -int'(err) : int'(err);
                    if (mag > turn_thr)
                        r.command = (err < 0) ? CMD_LEFT : CMD_RIGHT;
                    else if (mag < straight_thr)
                        r.command = CMD_FORWARD;
                    else
                        r.command = (err < 0) ? CMD_FRONT_LEFT : CMD_FRONT_RIGHT;
                    d2 = longint'(dx) * dx + longint'(dy) * dy;
                    r2 = longint'(arrive_rad) * arrive_rad;
                    if (d2 < r2)
                    begin
                        r.command = CMD_STOP;
                        r.arrived = 1'b1;
                        route_pos++;
                    end
                end
            end
            default: ;
        endcase
        r.route_done = (route_pos >= route_len);
        r.waypoint_index = OUT_IDX_W'(route_pos);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(21, 80);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d (result %0d)",
                 $time, what, got, want, results_seen);
        mismatches++;
    endtask

    task automatic queue_item(input logic [1:0] k, input int x, input int y, input int h);
        item_t it;
        it.kind = k;
        it.coord_x = 16'(x);
        it.coord_y = 16'(y);
        it.heading = 16'(h);
        pending_items.push_back(it);
        queued++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TURN_THR:     turn_thr = value;
            REG_STRAIGHT_THR: straight_thr = value;
            REG_ARRIVE_RAD:   arrive_rad = value;
            default: ;
        endcase
    endtask

    // Every queued item must have come back before the block counts as idle.
    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || results_seen < queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A short route, then poses that close in on each waypoint in turn.
    task automatic queue_route_run();
        int n;
        int span;
        int pick;
        int tries;
        int ox;
        int oy;
        int wx [6];
        int wy [6];
        pick = $urandom_range(0, 9);
        span = (pick < 6) ? 400 : ((pick < 9) ? 4000 : 32767);
        if ($urandom_range(0, 3) != 0)
            queue_item(KIND_CLEAR, $urandom, $urandom, $urandom);
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
        begin
            wx[k] = int'($urandom_range(0, 2 * span)) - span;
            wy[k] = int'($urandom_range(0, 2 * span)) - span;
            queue_item(KIND_APPEND, wx[k], wy[k], $urandom);
        end
        for (int k = 0; k < n; k++)
        begin
            tries = $urandom_range(1, 4);
            for (int s = 0; s < tries; s++)
            begin
                if (s == tries - 1)
                begin
                    ox = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 60)) - 30;
                    oy = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 60)) - 30;
                end
                else
                begin
                    ox = int'($urandom_range(0, 2 * span)) - span;
                    oy = int'($urandom_range(0, 2 * span)) - span;
                end
                queue_item(KIND_POSE, wx[k] + ox, wy[k] + oy, $urandom);
            end
        end
    endtask

    // Overfills the route so that the last appends are dropped.
    task automatic queue_overfill();
        queue_item(KIND_CLEAR, $urandom, $urandom, $urandom);
        for (int k = 0; k < ROUTE_DEPTH + 2; k++)
            queue_item(KIND_APPEND, $urandom, $urandom, $urandom);
        for (int k = 0; k < 3; k++)
            queue_item(KIND_POSE, $urandom, $urandom, $urandom);
    endtask

    task automatic queue_directed();
        queue_item(KIND_CLEAR, 0, 0, 0);
        queue_item(KIND_POSE, 0, 0, 0);                   // nothing to follow
        queue_item(KIND_APPEND, 1000, 0, 0);
        queue_item(KIND_POSE, 0, 0, 0);                   // dead ahead
        queue_item(KIND_POSE, 0, 0, 2000);
        queue_item(KIND_POSE, 0, 0, -2000);
        queue_item(KIND_POSE, 0, 0, 10000);
        queue_item(KIND_POSE, 0, 0, -10000);
        queue_item(KIND_POSE, 0, 0, -32768);
        queue_item(KIND_POSE, 0, 0, 32767);
        queue_item(KIND_POSE, 990, 0, 0);                 // inside the radius
        queue_item(KIND_POSE, 5, 5, 0);                   // route finished
        queue_item(KIND_APPEND, -32768, 32767, 0);
        queue_item(KIND_APPEND, 32767, -32768, 0);
        queue_item(KIND_POSE, 32767, -32768, -32768);     // farthest possible point
        queue_item(KIND_POSE, -32768, 32767, 32767);      // exactly on the waypoint
        queue_item(KIND_POSE, -32768, -32768, 0);
        queue_item(KIND_POSE, 32767, -32768, 0);
        queue_item(KIND_SPARE, -32768, 32767, -32768);
        queue_item(KIND_SPARE, 32767, -32768, 32767);
        queue_item(KIND_CLEAR, -1, -1, -1);
    endtask

    // Driver: one beat at a time from the queue, with random gaps unless no_gaps is set.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_results.push_back(steer_predict(item));
            if (!(item_valid && item_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    gap_left = no_gaps ? 0 : idle_len();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random unless no_gaps; one long hold-off backs the block up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!pressure_done && results_seen >= 150)
            begin
                hold_left = 400;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!no_gaps && $urandom_range(0, 7) == 0)
            begin
                hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 3);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                flag_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (result.command !== want.command)
                    flag_mismatch("command", result.command, want.command);
                if (result.arrived !== want.arrived)
                    flag_mismatch("arrived", result.arrived, want.arrived);
                if (result.route_done !== want.route_done)
                    flag_mismatch("route_done", result.route_done, want.route_done);
                if (result.waypoint_index !== want.waypoint_index)
                    flag_mismatch("waypoint_index", result.waypoint_index,
                                  want.waypoint_index);
                if (result.store_full !== want.store_full)
                    flag_mismatch("store_full", result.store_full, want.store_full);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("waypoint_heading_follower_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int turn_set [PHASES];
        int straight_set [PHASES];
        int radius_set [PHASES];
        int target;
        int pick;
        turn_set = '{3277, 0, 32767, 0, 1500};
        straight_set = '{910, 0, 32767, 0, 400};
        radius_set = '{50, 0, 4095, 0, 300};
        turn_set[3] = $urandom_range(0, 32767);
        straight_set[3] = $urandom_range(0, 32767);
        radius_set[3] = $urandom_range(0, 4095);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            write_reg(REG_TURN_THR, turn_set[ph]);
            write_reg(REG_STRAIGHT_THR, straight_set[ph]);
            write_reg(REG_ARRIVE_RAD, radius_set[ph]);
            no_gaps = (ph == 2);
            if (ph == 0)
                queue_directed();
            target = queued + ITEMS_PER_PHASE;
            while (queued < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 68)
                    queue_route_run();
                else if (pick < 95)
                    repeat ($urandom_range(1, 6))
                        queue_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                else
                    queue_overfill();
            end
        end
        wait_idle();
        if (mismatches == 0)
            $display("waypoint_heading_follower_top_tb: PASS");
        else
            $display("waypoint_heading_follower_top_tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/wpf_pkg.sv
hw/rtl/wpf_ram.sv
hw/rtl/wpf_cordic.sv
hw/rtl/waypoint_heading_follower_top.sv
tb/waypoint_heading_follower_top_tb.sv
